// ===== sv/b32c_pkg.sv =====
// Shared types, constants and the residue fold function for the base32 BCH checksum block.
`timescale 1ns / 1ps

package b32c_pkg;

    localparam int RES_W       = 40;
    localparam int SYM_W       = 5;
    localparam int RES_SYMS    = RES_W / SYM_W;
    localparam int MAX_CS_SYMS = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [RES_W-1:0] RES_ONES  = {RES_W{1'b1}};
    localparam logic [RES_W-1:0] RES_START = RES_W'(1);

    localparam logic [RES_W-1:0] GEN_WORDS [0:SYM_W-1] = '{
        40'h1ae45cd581, 40'h359aad8f02, 40'h61754f9b24,
        40'hc2ba1bb368, 40'hcd2623e3f0
    };

    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_VERIFY = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SYM  = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    typedef struct packed {
        logic             verify;
        logic             err;
        logic [RES_W-1:0] residue;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [RES_W-1:0] fold(input logic [RES_W-1:0] r,
                                               input logic [SYM_W-1:0] sym);
        logic [SYM_W-1:0] top;
        logic [RES_W-1:0] n;
        top = r[RES_W-1 -: SYM_W];
        n   = {r[RES_W-SYM_W-1:0], sym};
        for (int k = 0; k < SYM_W; k++) begin
            if (top[k]) begin
                n = n ^ GEN_WORDS[k];
            end
        end
        return n;
    endfunction

endpackage

// ===== sv/b32c_front.sv =====
// Front end: accepts items, folds data symbols into the residue, hands finishes to the queue.
`timescale 1ns / 1ps

module b32c_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,  // [4:0] symbol
    input  logic [3:0]             s_tuser,  // [1:0] operation, [2] skip_symbol, [3] bad_symbol
    input  b32c_pkg::q_stat_t      q_stat,
    output logic                   push,
    output b32c_pkg::job_t         push_job
);
    import b32c_pkg::*;

    logic [RES_W-1:0] residue_reg, residue_next;
    logic             err_reg, err_next;
    logic             accept;
    logic [1:0]       op;
    logic [SYM_W-1:0] sym;
    logic             skip, bad;

    assign op       = s_tuser[1:0];
    assign skip     = s_tuser[2];
    assign bad      = s_tuser[3];
    assign sym      = s_tdata[SYM_W-1:0];
    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (op == OP_CREATE || op == OP_VERIFY);

    assign push_job.verify  = (op == OP_VERIFY);
    assign push_job.err     = err_reg;
    assign push_job.residue = residue_reg;

    always_comb begin
        residue_next = residue_reg;
        err_next     = err_reg;
        if (accept) begin
            unique case (op)
                OP_DATA: begin
                    if (!skip) begin
                        if (bad) begin
                            err_next = 1'b1;
                        end else begin
                            residue_next = fold(residue_reg, sym);
                        end
                    end
                end
                OP_CREATE, OP_VERIFY: begin
                    residue_next = RES_START;
                    err_next     = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            residue_reg <= RES_START;
            err_reg     <= 1'b0;
        end else begin
            residue_reg <= residue_next;
            err_reg     <= err_next;
        end
    end

endmodule

// ===== sv/b32c_queue.sv =====
// Short queue of finish jobs between front and back.
`timescale 1ns / 1ps

module b32c_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  b32c_pkg::job_t         push_job,
    input  logic                   pop,
    output b32c_pkg::job_t         head_job,
    output b32c_pkg::q_stat_t      q_stat
);
    import b32c_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          mem [0:QUEUE_DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign q_stat.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_job     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/b32c_back.sv =====
// Back end: runs the zero-symbol folds of a create, emits checksum and status items.
`timescale 1ns / 1ps

module b32c_back #(
    parameter int CHECKSUM_SYMBOLS = b32c_pkg::MAX_CS_SYMS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  b32c_pkg::job_t         head_job,
    input  b32c_pkg::q_stat_t      q_stat,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,  // [4:0] checksum_symbol
    output logic [1:0]             m_tuser,  // [1:0] status
    output logic                   m_tlast
);
    import b32c_pkg::*;

    localparam int CNT_W = (CHECKSUM_SYMBOLS > 1) ? $clog2(CHECKSUM_SYMBOLS) : 1;
    localparam int ALIGN = SYM_W * (RES_SYMS - CHECKSUM_SYMBOLS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHECKSUM_SYMBOLS - 1);

    localparam logic [1:0] B_IDLE   = 2'd0;
    localparam logic [1:0] B_FOLD   = 2'd1;
    localparam logic [1:0] B_EMIT   = 2'd2;
    localparam logic [1:0] B_VERIFY = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RES_W-1:0] work_reg, work_next;
    logic             err_reg, err_next;
    logic             out_valid_reg, out_valid_next;
    logic [SYM_W-1:0] out_sym_reg, out_sym_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic             out_last_reg, out_last_next;
    logic             out_free;
    logic [RES_W-1:0] folded;

    assign out_free = !out_valid_reg || m_tready;
    assign folded   = fold(work_reg, '0);
    assign pop      = (state_reg == B_IDLE) && !q_stat.empty;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - SYM_W){1'b0}}, out_sym_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        work_next       = work_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_sym_next    = out_sym_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_stat.empty) begin
                    work_next  = head_job.residue;
                    err_next   = head_job.err;
                    cnt_next   = '0;
                    state_next = head_job.verify ? B_VERIFY : B_FOLD;
                end
            end
            B_FOLD: begin
                work_next = folded;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    work_next  = (folded ^ RES_ONES) << ALIGN;
                    cnt_next   = '0;
                    state_next = B_EMIT;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_sym_next    = err_reg ? '0 : work_reg[RES_W-1 -: SYM_W];
                    out_status_next = err_reg ? ST_BAD_SYM : ST_OK;
                    out_last_next   = (cnt_reg == CNT_LAST);
                    work_next       = work_reg << SYM_W;
                    cnt_next        = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_LAST) begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_VERIFY: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_sym_next    = '0;
                    out_last_next   = 1'b1;
                    out_status_next = err_reg ? ST_BAD_SYM :
                                      (work_reg != RES_ONES) ? ST_MISMATCH : ST_OK;
                    state_next      = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        work_reg       <= work_next;
        err_reg        <= err_next;
        out_sym_reg    <= out_sym_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/base32_bch_checksum_create_verify.sv =====
// Top level of the base32 BCH checksum create and verify block.
//
//   channel  dir  tdata           tuser                          tlast
//   s_       in   [4:0] symbol    [1:0] op, [2] skip, [3] bad    -
//   m_       out  [4:0] checksum  [1:0] status                   last of a finish
//
// Data items are taken one per cycle while s_tready is high; each is folded combinationally into the residue register.
// A finish is queued (two deep) and the residue restarts at once, so data keeps flowing.
// For a create the back end folds CHECKSUM_SYMBOLS zero symbols, then emits
// CHECKSUM_SYMBOLS items, one per cycle while m_ does not stall; a verify emits one item.
// Reset leaves the residue at 1, no error, queue and output register empty.
// s_tready drops only while the finish queue is full; m_ stalls hold the output register.
`timescale 1ns / 1ps

module base32_bch_checksum_create_verify #(
    parameter int CHECKSUM_SYMBOLS = b32c_pkg::MAX_CS_SYMS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // [4:0] symbol
    input  logic [3:0] s_tuser,  // [1:0] operation, [2] skip_symbol, [3] bad_symbol
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,  // [4:0] checksum_symbol
    output logic [1:0] m_tuser,  // [1:0] status
    output logic       m_tlast
);
    import b32c_pkg::*;

    logic    push, pop;
    job_t    push_job, head_job;
    q_stat_t q_stat;

    b32c_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    b32c_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    b32c_back #(
        .CHECKSUM_SYMBOLS (CHECKSUM_SYMBOLS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_stat.full))
        else $error("finish pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && q_stat.empty))
        else $error("pop from an empty queue");

    a_mismatch_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_MISMATCH) |-> (m_tlast && m_tdata == 8'd0))
        else $error("verify mismatch item not a single final item");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_BAD_SYM) |-> (m_tdata == 8'd0))
        else $error("error item carries a nonzero checksum symbol");

endmodule

// ===== sim/b32c_result_checker.sv =====
// Checker that predicts the checksum block's result items and compares them on the m_ channel.
`timescale 1ns / 1ps

module b32c_result_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,  // [4:0] symbol
    input  logic [3:0] s_tuser,  // [1:0] operation, [2] skip_symbol, [3] bad_symbol
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,  // [4:0] checksum_symbol
    input  logic [1:0] m_tuser,  // [1:0] status
    input  logic       m_tlast,
    output int         fail_count,
    output int         outstanding
);

    import b32c_pkg::*;

    localparam int CS_SYMS = MAX_CS_SYMS;

    localparam logic [39:0] BCH_GEN [5] = '{
        40'h1ae45cd581, 40'h359aad8f02, 40'h61754f9b24,
        40'hc2ba1bb368, 40'hcd2623e3f0
    };

    typedef struct packed {
        logic [4:0] cs;
        logic [1:0] status;
        logic       last;
    } cksum_item_t;

    cksum_item_t  checksum_items [$];
    cksum_item_t  got;
    cksum_item_t  want;
    logic [39:0]  bch_residue;
    logic [39:0]  tail;
    logic         bad_seen;
    logic [1:0]   in_op;
    logic [4:0]   in_sym;
    logic         in_skip;
    logic         in_bad;
    int           errs = 0;

    function automatic logic [39:0] bch_fold(input logic [39:0] acc, input logic [4:0] sym);
        logic [39:0] nxt;
        nxt = {acc[34:0], sym};
        for (int k = 0; k < 5; k++) begin
            if (acc[35 + k]) begin
                nxt = nxt ^ BCH_GEN[k];
            end
        end
        return nxt;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            checksum_items.delete();
            bch_residue = 40'd1;
            bad_seen    = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{cs: m_tdata[4:0], status: m_tuser, last: m_tlast};
                if (checksum_items.size() == 0) begin
                    $display("%0t: expected none, actual %0d/%0d/%0d (cs/st/last)",
                             $time, got.cs, got.status, got.last);
                    errs++;
                end else begin
                    want = checksum_items.pop_front();
                    if (got != want || m_tdata[7:5] != 3'd0) begin
                        $display("%0t: expected %0d/%0d/%0d actual %0d/%0d/%0d (cs/st/last)",
                                 $time, want.cs, want.status, want.last,
                                 m_tdata, got.status, got.last);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                in_op   = s_tuser[1:0];
                in_skip = s_tuser[2];
                in_bad  = s_tuser[3];
                in_sym  = s_tdata[4:0];
                case (in_op)
                    OP_DATA: begin
                        if (!in_skip) begin
                            if (in_bad) begin
                                bad_seen = 1'b1;
                            end else begin
                                bch_residue = bch_fold(bch_residue, in_sym);
                            end
                        end
                    end
                    OP_CREATE: begin
                        tail = bch_residue;
                        for (int i = 0; i < CS_SYMS; i++) begin
                            tail = bch_fold(tail, 5'd0);
                        end
                        tail = ~tail;
                        for (int i = 0; i < CS_SYMS; i++) begin
                            want.cs     = bad_seen ? 5'd0 : tail[5 * (CS_SYMS - 1 - i) +: 5];
                            want.status = bad_seen ? ST_BAD_SYM : ST_OK;
                            want.last   = (i == CS_SYMS - 1);
                            checksum_items.push_back(want);
                        end
                        bch_residue = 40'd1;
                        bad_seen    = 1'b0;
                    end
                    OP_VERIFY: begin
                        want.cs     = 5'd0;
                        want.last   = 1'b1;
                        if (bad_seen) begin
                            want.status = ST_BAD_SYM;
                        end else if (bch_residue != {40{1'b1}}) begin
                            want.status = ST_MISMATCH;
                        end else begin
                            want.status = ST_OK;
                        end
                        checksum_items.push_back(want);
                        bch_residue = 40'd1;
                        bad_seen    = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        fail_count  <= errs;
        outstanding <= checksum_items.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top that drives symbol and finish items into the checksum block and gives the verdict.
`timescale 1ns / 1ps

module tb_top;

    import b32c_pkg::*;

    localparam logic [1:0] OP_IGNORED = 2'd3;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;  // [4:0] symbol
    logic [3:0] s_tuser  = 4'd0;  // [1:0] operation, [2] skip_symbol, [3] bad_symbol
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [4:0] checksum_symbol
    logic [1:0] m_tuser;          // [1:0] status
    logic       m_tlast;

    int         fail_count;
    int         outstanding;
    int         send_idle = 16;
    int         recv_idle = 71;
    int         n_sent    = 0;
    logic [4:0] created_syms [$];
    logic [4:0] word_syms [$];

    base32_bch_checksum_create_verify i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    b32c_result_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // keep the checksum symbols of the latest create for replay
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            created_syms.push_back(m_tdata[4:0]);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [4:0] sym,
                             input logic skip, input logic bad);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, sym};
        s_tuser  <= {bad, skip, op};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        n_sent++;
    endtask

    task automatic send_finish(input logic [1:0] op);
        send_item(op, 5'($urandom_range(31)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // hold off until every expected item has come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic feed_word();
        foreach (word_syms[i]) begin
            if ($urandom_range(7) == 0) begin
                send_item(OP_DATA, 5'($urandom_range(31)), 1'b1, 1'($urandom_range(1)));
            end
            send_item(OP_DATA, word_syms[i], 1'b0, 1'b0);
        end
    endtask

    task automatic round_trip(input int len, input logic corrupt);
        int idx;
        drain();
        created_syms.delete();
        word_syms.delete();
        for (int i = 0; i < len; i++) begin
            word_syms.push_back(5'($urandom_range(31)));
        end
        feed_word();
        send_finish(OP_CREATE);
        drain();
        if (created_syms.size() == MAX_CS_SYMS) begin
            foreach (created_syms[i]) begin
                word_syms.push_back(created_syms[i]);
            end
        end
        if (corrupt && word_syms.size() > 0) begin
            idx = $urandom_range(word_syms.size() - 1);
            word_syms[idx] = word_syms[idx] ^ 5'(1 << $urandom_range(4));
        end
        feed_word();
        send_finish(OP_VERIFY);
    endtask

    initial begin
        int kind;
        int n;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        send_item(OP_DATA, 5'd0, 1'b0, 1'b0);
        send_item(OP_DATA, 5'd31, 1'b0, 1'b0);
        send_item(OP_DATA, 5'd21, 1'b1, 1'b0);
        send_item(OP_DATA, 5'd10, 1'b1, 1'b1);
        send_item(OP_IGNORED, 5'd31, 1'b1, 1'b1);
        send_item(OP_CREATE, 5'd31, 1'b0, 1'b0);
        send_item(OP_VERIFY, 5'd0, 1'b1, 1'b0);
        send_item(OP_DATA, 5'd5, 1'b0, 1'b0);
        send_item(OP_DATA, 5'd17, 1'b0, 1'b1);
        send_item(OP_DATA, 5'd7, 1'b0, 1'b0);
        send_item(OP_CREATE, 5'd0, 1'b1, 1'b1);
        send_item(OP_DATA, 5'd31, 1'b0, 1'b1);
        send_item(OP_VERIFY, 5'd31, 1'b0, 1'b1);
        send_item(OP_CREATE, 5'd12, 1'b0, 1'b0);
        round_trip(3, 1'b0);

        while (n_sent < 210) begin
            if (n_sent < 90) begin
                send_idle = 16;
                recv_idle = 71;
            end else if (n_sent < 150) begin
                send_idle = 71;
                recv_idle = 16;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            kind = $urandom_range(9);
            if (kind < 5) begin
                round_trip($urandom_range(10), ($urandom_range(3) == 0));
            end else if (kind < 7) begin
                repeat (3) begin
                    n = $urandom_range(6);
                    repeat (n) begin
                        send_item(OP_DATA, 5'($urandom_range(31)),
                                  ($urandom_range(9) == 0), ($urandom_range(9) == 0));
                    end
                    send_finish($urandom_range(1) ? OP_CREATE : OP_VERIFY);
                end
            end else if (kind < 9) begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    send_item(2'($urandom_range(3)), 5'($urandom_range(31)),
                              ($urandom_range(4) == 0), ($urandom_range(4) == 0));
                end
            end else begin
                n = $urandom_range(5);
                repeat (n) send_item(OP_DATA, 5'($urandom_range(31)), 1'b0, 1'b0);
                send_item(OP_DATA, 5'($urandom_range(31)), 1'b0, 1'b1);
                n = $urandom_range(5);
                repeat (n) send_item(OP_DATA, 5'($urandom_range(31)), 1'b0, 1'b0);
                send_finish($urandom_range(1) ? OP_CREATE : OP_VERIFY);
            end
        end

        drain();
        repeat (40) @(negedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/b32c_pkg.sv
sv/b32c_front.sv
sv/b32c_queue.sv
sv/b32c_back.sv
sv/base32_bch_checksum_create_verify.sv
sim/b32c_result_checker.sv
sim/tb_top.sv
